FILE: hdl/modular_inverse_assert.svh
// ----------------------------------------------------------------------------
// Modular inverse assertion macros
// Shorthand for the concurrent checks used by the modular inverse checker.
// ----------------------------------------------------------------------------
`ifndef MODULAR_INVERSE_ASSERT_SVH
`define MODULAR_INVERSE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define MI_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define MI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/modinv_pkg.sv
// ----------------------------------------------------------------------------
// Modular inverse package
// Beat types and shared constants of the modular inverse block.
// ----------------------------------------------------------------------------
package modinv_pkg;

   localparam int FIELD_WIDTH   = 32;
   localparam int DEFAULT_WIDTH = 32;

   typedef struct packed {
      logic [FIELD_WIDTH-1:0] value;
      logic [FIELD_WIDTH-1:0] modulus;
   } req_type;

   typedef struct packed {
      logic [FIELD_WIDTH-1:0] inverse;
      logic                   exists;
   } rsp_type;

endpackage

FILE: hdl/modinv_alu.sv
// ----------------------------------------------------------------------------
// Modular inverse arithmetic unit
// Compare, subtract and add unit shared by the sequencer's arithmetic steps.
// ----------------------------------------------------------------------------
module modinv_alu #(
   parameter int WIDTH = modinv_pkg::DEFAULT_WIDTH
) (
   input  logic [WIDTH-1:0] op_a,
   input  logic [WIDTH-1:0] op_b,
   input  logic [WIDTH-1:0] acc,
   input  logic [WIDTH-1:0] addend,
   output logic             le,
   output logic [WIDTH-1:0] diff,
   output logic [WIDTH-1:0] sum
);

   logic [WIDTH:0] wide_diff;

   assign wide_diff = {1'b0, op_b} - {1'b0, op_a};
   assign le        = ~wide_diff[WIDTH];
   assign diff      = wide_diff[WIDTH-1:0];
   assign sum       = acc + addend;

endmodule

FILE: hdl/modular_inverse.sv
// ----------------------------------------------------------------------------
// Modular inverse
// Extended Euclidean modular inverse on one shared compare/subtract unit.
// ----------------------------------------------------------------------------
// A request beat on req_data (value, modulus) is taken at a rising edge where
// start is high and busy is low. busy then stays high until the result is out.
// The result beat appears on rsp_data for exactly one cycle, marked by
// rsp_valid; the receiver cannot hold it off and must take it in that cycle.
// inverse lies in 0 to modulus-1; exists is low, with inverse zero, when the
// gcd is not one or the modulus is zero.
// A zero modulus answers in the cycle after the request with busy never set.
// Otherwise each quotient of the Euclid chain, the first reduction of value
// by modulus included, is found by shift-and-subtract on the shared unit:
// an align phase, a subtract phase and a swap. A fix step then reduces the
// result by the modulus and a negate step fixes the sign; the fix step
// alone answers when no inverse exists or the modulus is one.
// Consecutive Fibonacci numbers are the slowest inputs.
// One request is worked on at a time; the next is taken once busy falls,
// which is the cycle in which the result is shown.
// A synchronous reset returns the sequencer to idle and drops rsp_valid.
// ----------------------------------------------------------------------------
module modular_inverse #(
   parameter int WIDTH = modinv_pkg::DEFAULT_WIDTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  modinv_pkg::req_type req_data,
   output logic                rsp_valid,
   output modinv_pkg::rsp_type rsp_data
);

   localparam int KW  = $clog2(WIDTH);
   localparam int INW = (WIDTH < modinv_pkg::FIELD_WIDTH) ? WIDTH : modinv_pkg::FIELD_WIDTH;
   localparam int FW  = modinv_pkg::FIELD_WIDTH;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ALIGN,
      ST_SUB,
      ST_SWAP,
      ST_FIX,
      ST_NEG
   } state_type;

   state_type           state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   modinv_pkg::rsp_type rsp_ff, rsp_in;
   logic [WIDTH-1:0]    m_ff, m_in;
   logic [WIDTH-1:0]    r_ff, r_in;
   logic [WIDTH-1:0]    d_ff, d_in;
   logic [WIDTH-1:0]    rs_ff, rs_in;
   logic [WIDTH-1:0]    ua_ff, ua_in;
   logic [WIDTH-1:0]    ub_ff, ub_in;
   logic [WIDTH-1:0]    us_ff, us_in;
   logic [KW-1:0]       k_ff, k_in;
   logic                reduce_ff, reduce_in;
   logic                odd_ff, odd_in;
   logic                any_ff, any_in;

   logic [WIDTH-1:0]    op_a, op_b, acc, addend, diff, sum;
   logic                le;
   logic [WIDTH-1:0]    a_new, m_new;

   assign a_new = WIDTH'(req_data.value[INW-1:0]);
   assign m_new = WIDTH'(req_data.modulus[INW-1:0]);

   modinv_alu #(
      .WIDTH (WIDTH)
   ) u_alu (
      .op_a   (op_a),
      .op_b   (op_b),
      .acc    (acc),
      .addend (addend),
      .le     (le),
      .diff   (diff),
      .sum    (sum)
   );

   always_comb begin
      op_a   = rs_ff;
      op_b   = r_ff;
      acc    = ua_ff;
      addend = us_ff;
      unique case (state_ff)
         ST_ALIGN: begin
            op_a = rs_ff << 1;
         end
         ST_FIX: begin
            op_a = m_ff;
            op_b = ua_ff;
         end
         ST_NEG: begin
            op_a = ua_ff;
            op_b = m_ff;
         end
         default: begin
            op_a = rs_ff;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      m_in         = m_ff;
      r_in         = r_ff;
      d_in         = d_ff;
      rs_in        = rs_ff;
      ua_in        = ua_ff;
      ub_in        = ub_ff;
      us_in        = us_ff;
      k_in         = k_ff;
      reduce_in    = reduce_ff;
      odd_in       = odd_ff;
      any_in       = any_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               m_in = m_new;
               if (m_new == '0) begin
                  rsp_valid_in   = 1'b1;
                  rsp_in.inverse = '0;
                  rsp_in.exists  = 1'b0;
               end else begin
                  r_in      = a_new;
                  d_in      = m_new;
                  rs_in     = m_new;
                  us_in     = '0;
                  k_in      = '0;
                  reduce_in = 1'b1;
                  state_in  = ST_ALIGN;
               end
            end
         end
         ST_ALIGN: begin
            if (!rs_ff[WIDTH-1] && le) begin
               rs_in = rs_ff << 1;
               us_in = us_ff << 1;
               k_in  = k_ff + KW'(1);
            end else begin
               state_in = ST_SUB;
            end
         end
         ST_SUB: begin
            if (le) begin
               r_in = diff;
               if (!reduce_ff) begin
                  ua_in = sum;
               end
            end
            if (k_ff == '0) begin
               state_in = ST_SWAP;
            end else begin
               rs_in = rs_ff >> 1;
               us_in = us_ff >> 1;
               k_in  = k_ff - KW'(1);
            end
         end
         ST_SWAP: begin
            r_in  = d_ff;
            d_in  = r_ff;
            rs_in = r_ff;
            k_in  = '0;
            if (reduce_ff) begin
               ua_in     = '0;
               ub_in     = WIDTH'(1);
               us_in     = WIDTH'(1);
               reduce_in = 1'b0;
               odd_in    = 1'b0;
               any_in    = 1'b0;
            end else begin
               ua_in  = ub_ff;
               ub_in  = ua_ff;
               us_in  = ua_ff;
               odd_in = ~odd_ff;
               any_in = 1'b1;
            end
            state_in = (r_ff == '0) ? ST_FIX : ST_ALIGN;
         end
         ST_FIX: begin
            if (r_ff != WIDTH'(1)) begin
               rsp_valid_in   = 1'b1;
               rsp_in.inverse = '0;
               rsp_in.exists  = 1'b0;
               state_in       = ST_IDLE;
            end else if (!any_ff) begin
               rsp_valid_in   = 1'b1;
               rsp_in.inverse = '0;
               rsp_in.exists  = 1'b1;
               state_in       = ST_IDLE;
            end else begin
               if (le) begin
                  ua_in = diff;
               end
               state_in = ST_NEG;
            end
         end
         ST_NEG: begin
            rsp_valid_in  = 1'b1;
            rsp_in.exists = 1'b1;
            if (odd_ff || ua_ff == '0) begin
               rsp_in.inverse = FW'(ua_ff);
            end else begin
               rsp_in.inverse = FW'(diff);
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff    <= rsp_in;
      m_ff      <= m_in;
      r_ff      <= r_in;
      d_ff      <= d_in;
      rs_ff     <= rs_in;
      ua_ff     <= ua_in;
      ub_ff     <= ub_in;
      us_ff     <= us_in;
      k_ff      <= k_in;
      reduce_ff <= reduce_in;
      odd_ff    <= odd_in;
      any_ff    <= any_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: hdl/modinv_checker.sv
// ----------------------------------------------------------------------------
// Modular inverse checker
// Port-level checks on the modular inverse block, bound to its top level.
// ----------------------------------------------------------------------------
`include "modular_inverse_assert.svh"

module modinv_checker (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input modinv_pkg::req_type req_data,
   input logic                rsp_valid,
   input modinv_pkg::rsp_type rsp_data
);

   `MI_ASSERT_IMPLY(a_none_is_zero, clock, reset, rsp_valid && !rsp_data.exists, rsp_data.inverse == '0, "missing inverse must read as zero")
   `MI_ASSERT_NEXT(a_zero_modulus, clock, reset, start && !busy && req_data.modulus == '0, rsp_valid && !rsp_data.exists, "zero modulus must answer at once without inverse")
   `MI_ASSERT_IMPLY(a_idle_on_result, clock, reset, rsp_valid, !busy, "block must be idle while a result beat is shown")
   `MI_ASSERT_NEXT(a_no_spurious, clock, reset, !busy && !start, !rsp_valid, "result beat without a request")

endmodule

bind modular_inverse modinv_checker u_modinv_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
